>>> hw/rtl/rsf_pkg.sv
// ---------------------------------------------------------------------------
// rsf_pkg: shared types and constants for the record stack with filter
// Command and status codes, per-cell operation codes and default sizes.
// ---------------------------------------------------------------------------
package rsf_pkg;

	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_COUNT_BITS  = 8;

	localparam int CMD_W      = 3;
	localparam int STAT_W     = 2;
	localparam int CNT_IO_W   = 8;
	localparam int NAME_W     = 64;
	localparam int LEVEL_W    = 7;
	localparam int CAP_W      = 7;
	localparam int KEY_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(50);
	localparam logic [KEY_W-1:0] KEY_RESET = KEY_W'(2);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_PEEK   = 3'd2,
		CMD_DUP    = 3'd3,
		CMD_SWAP   = 3'd4,
		CMD_FILTER = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_ONE   = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAPACITY = 1'd0,
		REG_DROP_KEY = 1'd1
	} cfg_reg_t;

	// What every cell of the chain does in a cycle
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SHIFT_DN,
		OP_SHIFT_UP,
		OP_DUP,
		OP_SWAP,
		OP_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     clear_name;
	} cell_ctrl_t;

endpackage

>>> hw/rtl/record_stack_with_filter.sv
// ---------------------------------------------------------------------------
// record_stack_with_filter: bounded stack of (count, name) records
// A chain of slot cells with the top of stack in cell 0, plus a small
// controller for push, pop, peek, duplicate, swap and filter.
// ---------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_* channel (valid/ready); every command gives one
//   result transfer on the out_* channel (status, record, fill level, number
//   removed). Registers capacity (index 0) and drop_key (index 1) are written
//   on the cfg_* channel, which is always ready; write them only while idle.
//   Push, pop, peek, duplicate and swap finish in the accept cycle: the result
//   is registered and shows in the cycle after the transfer, and a new command
//   can follow every cycle while out_ready stays high.
//   Filter rotates the chain once per held entry, then closes the walk in a
//   final step that loads the result, and in_ready stays low until the result
//   is in the output register.
//   A result waiting in the output register is held while out_ready is low;
//   in_ready is low then, unless the waiting result is taken in that cycle.
//   Reset empties the stack and restores capacity 50 and drop_key 2; slot
//   contents are not cleared, only entries below the fill level are ever read.
// ---------------------------------------------------------------------------
module record_stack_with_filter import rsf_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      command,
	input  logic [CNT_IO_W-1:0]   count_in,
	input  logic [NAME_W-1:0]     name_in,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STAT_W-1:0]     status,
	output logic [CNT_IO_W-1:0]   count_out,
	output logic [NAME_W-1:0]     name_out,
	output logic [LEVEL_W-1:0]    fill_level,
	output logic [LEVEL_W-1:0]    removed_total,
	// configuration channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PTR_W = $clog2(STACK_DEPTH + 1);
	localparam int FW    = (PTR_W > LEVEL_W) ? PTR_W : LEVEL_W;
	localparam int CMP_W = (COUNT_BITS > CNT_IO_W) ? COUNT_BITS : CNT_IO_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_FILT = 2'b10
	} state_t;

	state_t            state_q;
	logic [PTR_W-1:0]  fill_q;
	logic [PTR_W-1:0]  rem_q;     // entries still to visit in the filter walk
	logic [PTR_W-1:0]  len_q;     // entries left after drops so far
	logic [PTR_W-1:0]  start_q;   // fill level when the filter began
	logic [CAP_W-1:0]  cap_q;
	logic [KEY_W-1:0]  key_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] stat_q;
	logic [CNT_IO_W-1:0] cnt_out_q;
	logic [NAME_W-1:0] name_out_q;
	logic [LEVEL_W-1:0] level_q;
	logic [LEVEL_W-1:0] removed_q;

	// chain taps
	logic [COUNT_BITS-1:0] cell_cnt  [STACK_DEPTH];
	logic [NAME_W-1:0]     cell_name [STACK_DEPTH];

	cell_ctrl_t        ctrl;
	logic [PTR_W-1:0]  place;
	logic [COUNT_BITS-1:0] push_cnt;
	logic [CMP_W-1:0]  cin_ext;
	logic [CMP_W-1:0]  top_ext;
	logic              top_drop;
	logic              accept;
	logic              full;
	logic              empty;
	logic [FW-1:0]     cap_eff;

	// next-state signals
	logic              load_out;
	logic [STAT_W-1:0] stat_d;
	logic              take_top;
	logic [PTR_W-1:0]  fill_d;
	logic              start_filt;
	logic              end_filt;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;

	assign cin_ext  = CMP_W'(count_in);
	assign push_cnt = cin_ext[COUNT_BITS-1:0];
	assign top_ext  = CMP_W'(cell_cnt[0]);
	assign top_drop = (top_ext == CMP_W'(key_q));

	assign cap_eff = (FW'(cap_q) > FW'(STACK_DEPTH)) ? FW'(STACK_DEPTH) : FW'(cap_q);
	assign full    = (FW'(fill_q) >= cap_eff);
	assign empty   = (fill_q == '0);
	assign place   = len_q - PTR_W'(1);

	always_comb begin
		ctrl.op         = OP_HOLD;
		ctrl.clear_name = 1'b0;
		load_out        = 1'b0;
		stat_d          = STAT_OK;
		take_top        = 1'b0;
		fill_d          = fill_q;
		start_filt      = 1'b0;
		end_filt        = 1'b0;
		if (state_q == ST_FILT) begin
			if (rem_q != '0) begin
				ctrl.op = OP_ROT;
			end else begin
				end_filt = 1'b1;
				load_out = 1'b1;
				fill_d   = len_q;
			end
		end else if (accept) begin
			load_out = 1'b1;
			case (command)
				CMD_PUSH: begin
					if (full) begin
						stat_d = STAT_FULL;
					end else begin
						ctrl.op = OP_SHIFT_DN;
						fill_d  = fill_q + PTR_W'(1);
					end
				end
				CMD_POP: begin
					if (empty) begin
						stat_d = STAT_EMPTY;
					end else begin
						take_top = 1'b1;
						ctrl.op  = OP_SHIFT_UP;
						fill_d   = fill_q - PTR_W'(1);
					end
				end
				CMD_PEEK: begin
					if (empty) begin
						stat_d = STAT_EMPTY;
					end else begin
						take_top = 1'b1;
					end
				end
				CMD_DUP: begin
					if (empty) begin
						stat_d = STAT_EMPTY;
					end else if (full) begin
						stat_d = STAT_FULL;
					end else begin
						ctrl.op = OP_DUP;
						fill_d  = fill_q + PTR_W'(1);
					end
				end
				CMD_SWAP: begin
					if (empty) begin
						stat_d = STAT_EMPTY;
					end else if (fill_q == PTR_W'(1)) begin
						stat_d = STAT_ONE;
					end else begin
						ctrl.op = OP_SWAP;
					end
				end
				CMD_FILTER: begin
					// result comes at the end of the walk
					load_out   = 1'b0;
					start_filt = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// chain of slots, cell 0 is the top of stack
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [COUNT_BITS-1:0] up_cnt;
		logic [NAME_W-1:0]     up_name;
		logic [COUNT_BITS-1:0] dn_cnt;
		logic [NAME_W-1:0]     dn_name;

		if (i == 0) begin : g_top
			assign up_cnt  = push_cnt;
			assign up_name = name_in;
		end else begin : g_mid
			assign up_cnt  = cell_cnt[i-1];
			assign up_name = cell_name[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_bot
			assign dn_cnt  = '0;
			assign dn_name = '0;
		end else begin : g_low
			assign dn_cnt  = cell_cnt[i+1];
			assign dn_name = cell_name[i+1];
		end

		rsf_cell #(
			.COUNT_BITS (COUNT_BITS),
			.PTR_W      (PTR_W),
			.INDEX      (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.place     (place),
			.up_cnt    (up_cnt),
			.up_name   (up_name),
			.dn_cnt    (dn_cnt),
			.dn_name   (dn_name),
			.head_cnt  (cell_cnt[0]),
			.head_name (cell_name[0]),
			.cnt_q     (cell_cnt[i]),
			.name_q    (cell_name[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			rem_q       <= '0;
			len_q       <= '0;
			start_q     <= '0;
			cap_q       <= CAP_RESET;
			key_q       <= KEY_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CAPACITY: cap_q <= cfg_data[CAP_W-1:0];
					REG_DROP_KEY: key_q <= cfg_data[KEY_W-1:0];
					default: begin
					end
				endcase
			end

			fill_q <= fill_d;

			if (start_filt) begin
				state_q <= ST_FILT;
				rem_q   <= fill_q;
				len_q   <= fill_q;
				start_q <= fill_q;
			end else if (end_filt) begin
				state_q <= ST_IDLE;
			end else if (state_q == ST_FILT) begin
				// advance the walk; a dropped head shortens the stack
				rem_q <= rem_q - PTR_W'(1);
				if (top_drop) begin
					len_q <= len_q - PTR_W'(1);
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			stat_q  <= stat_d;
			level_q <= LEVEL_W'(FW'(fill_d));
			if (take_top) begin
				cnt_out_q  <= top_ext[CNT_IO_W-1:0];
				name_out_q <= cell_name[0];
			end else begin
				cnt_out_q  <= '0;
				name_out_q <= '0;
			end
			if (end_filt) begin
				removed_q <= LEVEL_W'(FW'(start_q - len_q));
			end else begin
				removed_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = stat_q;
	assign count_out     = cnt_out_q;
	assign name_out      = name_out_q;
	assign fill_level    = level_q;
	assign removed_total = removed_q;

endmodule

>>> hw/rtl/rsf_cell.sv
// ---------------------------------------------------------------------------
// rsf_cell: one stack slot of the cell chain
// Holds one record and takes its next value from itself, its upper or lower
// neighbor, or the broadcast head record, as the chain operation says.
// ---------------------------------------------------------------------------
module rsf_cell import rsf_pkg::*; #(
	parameter int COUNT_BITS = DEF_COUNT_BITS,
	parameter int PTR_W      = 7,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	input  logic [PTR_W-1:0]      place,
	input  logic [COUNT_BITS-1:0] up_cnt,
	input  logic [NAME_W-1:0]     up_name,
	input  logic [COUNT_BITS-1:0] dn_cnt,
	input  logic [NAME_W-1:0]     dn_name,
	input  logic [COUNT_BITS-1:0] head_cnt,
	input  logic [NAME_W-1:0]     head_name,
	output logic [COUNT_BITS-1:0] cnt_q,
	output logic [NAME_W-1:0]     name_q
);

	logic [COUNT_BITS-1:0] cnt_d;
	logic [NAME_W-1:0]     name_d;
	logic                  at_place;

	assign at_place = (place == PTR_W'(INDEX));

	always_comb begin
		cnt_d  = cnt_q;
		name_d = name_q;
		case (ctrl.op)
			OP_HOLD: begin
			end
			OP_SHIFT_DN: begin
				cnt_d  = up_cnt;
				name_d = up_name;
			end
			OP_SHIFT_UP: begin
				cnt_d  = dn_cnt;
				name_d = dn_name;
			end
			OP_DUP: begin
				if (INDEX != 0) begin
					cnt_d  = up_cnt;
					name_d = up_name;
				end
			end
			OP_SWAP: begin
				if (INDEX == 0) begin
					cnt_d  = dn_cnt;
					name_d = dn_name;
				end else if (INDEX == 1) begin
					cnt_d  = up_cnt;
					name_d = up_name;
				end
			end
			OP_ROT: begin
				if (at_place) begin
					cnt_d  = head_cnt;
					name_d = head_name;
				end else begin
					cnt_d  = dn_cnt;
					name_d = dn_name;
				end
			end
			default: begin
			end
		endcase
		if (ctrl.clear_name) begin
			name_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q  <= cnt_d;
		name_q <= name_d;
	end

endmodule
